FILE: hdl/jac_pkg.sv
// Shared types and constants for the joystick axis conditioner.
// No dependencies; used by jac_ctrl, jac_datapath and the top level.
package jac_pkg;

    localparam int AXIS_W       = 4;
    localparam int SAMPLE_W     = 16;
    localparam int VAL_W        = 18;   // signed Q2.16, range -65536..65536
    localparam int ACC_W        = 27;   // EMA accumulator
    localparam int COEF_W       = 8;    // Q0.8 table entries
    localparam int TABLE_W      = 64;
    localparam int DIV_STEPS    = 17;   // quotient bits of the deadzone rescale
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W    = 2;
    localparam int NUM_AXES_DEF = 8;

    localparam logic signed [VAL_W-1:0] ONE_Q16  = 18'sd65536;
    localparam logic signed [VAL_W-1:0] HALF_Q16 = 18'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT    = 2'd0,
        CFG_DEADZONE  = 2'd1,
        CFG_SMOOTHING = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_DZ,
        S_DIV,
        S_DZ_FIN,
        S_EMA1,
        S_EMA2,
        S_EMA3,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic dz_init;
        logic div_step;
        logic dz_fin;
        logic ema_bypass;
        logic mul1;
        logic mul2;
        logic ema_fin;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_needed;
        logic smooth;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/jac_ctrl.sv
// Sequencer for the joystick axis conditioner.
// Depends on jac_pkg; drives the command struct of jac_datapath.
module jac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  jac_pkg::t_dp_stat i_stat,
    output jac_pkg::t_dp_cmd  o_cmd
);

    jac_pkg::t_state               r_state, n_state;
    logic [jac_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jac_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            jac_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = jac_pkg::S_CONV;
                end
            end
            jac_pkg::S_CONV: begin
                o_cmd.conv = 1'b1;
                n_state    = jac_pkg::S_DZ;
            end
            jac_pkg::S_DZ: begin
                o_cmd.dz_init = 1'b1;
                n_cnt         = '0;
                n_state       = i_stat.div_needed ? jac_pkg::S_DIV : jac_pkg::S_EMA1;
            end
            jac_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == jac_pkg::CNT_W'(jac_pkg::DIV_STEPS - 1)) begin
                    n_state = jac_pkg::S_DZ_FIN;
                end
            end
            jac_pkg::S_DZ_FIN: begin
                o_cmd.dz_fin = 1'b1;
                n_state      = jac_pkg::S_EMA1;
            end
            jac_pkg::S_EMA1: begin
                if (i_stat.smooth) begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = jac_pkg::S_EMA2;
                end else begin
                    o_cmd.ema_bypass = 1'b1;
                    n_state          = jac_pkg::S_OUT;
                end
            end
            jac_pkg::S_EMA2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = jac_pkg::S_EMA3;
            end
            jac_pkg::S_EMA3: begin
                o_cmd.ema_fin = 1'b1;
                n_state       = jac_pkg::S_OUT;
            end
            jac_pkg::S_OUT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = jac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jac_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/jac_datapath.sv
// Datapath of the joystick axis conditioner: config registers, conversion,
// deadzone divider, EMA state and multiplier, output scaling. Depends on jac_pkg.
module jac_datapath #(
    parameter int NUM_AXES = jac_pkg::NUM_AXES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jac_pkg::TABLE_W-1:0]         i_cfg_data,
    input  logic [jac_pkg::AXIS_W-1:0]          i_axis_index,
    input  logic signed [jac_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_source_signed,
    input  logic                                i_source_present,
    input  logic                                i_restart,
    input  jac_pkg::t_dp_cmd                    i_cmd,
    output jac_pkg::t_dp_stat                   o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [jac_pkg::AXIS_W-1:0]          o_axis_out,
    output logic signed [jac_pkg::SAMPLE_W-1:0] o_output_value
);

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int AXN_W = jac_pkg::AXIS_W + 1;
    localparam int VW    = jac_pkg::VAL_W;
    localparam int AW    = jac_pkg::ACC_W;
    localparam int CW    = jac_pkg::COEF_W;

    // configuration
    logic [CW-1:0]                 r_invert;
    logic [jac_pkg::TABLE_W-1:0]   r_dz_tab;
    logic [jac_pkg::TABLE_W-1:0]   r_alpha_tab;

    // captured request
    logic [jac_pkg::AXIS_W-1:0]          r_axis;
    logic signed [jac_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_sgn;
    logic                                r_present;

    // working value, divider, accumulator
    logic signed [VW-1:0] r_v;
    logic                 r_neg;
    logic [15:0]          r_den;
    logic [15:0]          r_rem;
    logic [16:0]          r_quo;
    logic signed [AW-1:0] r_acc;

    // EMA state
    logic signed [VW-1:0] r_ema [NUM_AXES];
    logic [NUM_AXES-1:0]  r_ema_valid;

    // output register
    logic                                r_out_valid;
    logic [jac_pkg::AXIS_W-1:0]          r_out_axis;
    logic signed [jac_pkg::SAMPLE_W-1:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert    <= '0;
            r_dz_tab    <= '0;
            r_alpha_tab <= '0;
        end else if (i_cfg_we) begin
            unique case (jac_pkg::t_cfg_index'(i_cfg_index))
                jac_pkg::CFG_INVERT:    r_invert    <= i_cfg_data[CW-1:0];
                jac_pkg::CFG_DEADZONE:  r_dz_tab    <= i_cfg_data;
                jac_pkg::CFG_SMOOTHING: r_alpha_tab <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // axis decode
    logic [AXN_W-1:0] w_axis_x;
    logic             w_cond, w_slider, w_hat, w_low8, w_inv;
    logic [5:0]       w_sel;
    logic [CW-1:0]    w_d, w_a;
    logic [IDX_W-1:0] w_idx;

    assign w_axis_x = {1'b0, r_axis};
    assign w_cond   = r_present && (w_axis_x < AXN_W'(NUM_AXES));
    assign w_slider = (w_axis_x + AXN_W'(2)) >= AXN_W'(NUM_AXES);
    assign w_hat    = r_present && (w_axis_x == AXN_W'(NUM_AXES));
    assign w_low8   = !r_axis[3];
    assign w_sel    = {r_axis[2:0], 3'b000};
    assign w_d      = w_low8 ? r_dz_tab[w_sel +: CW] : '0;
    assign w_a      = w_low8 ? r_alpha_tab[w_sel +: CW] : '0;
    assign w_inv    = w_low8 && r_invert[r_axis[2:0]];
    assign w_idx    = r_axis[IDX_W-1:0];

    // conversion to Q2.16
    logic signed [jac_pkg::SAMPLE_W-1:0] w_s_clamp;
    logic signed [VW-1:0]                w_se, w_raw, w_conv;

    always_comb begin
        w_s_clamp = (!r_sgn && r_sample < 0) ? 16'sd0 : r_sample;
        w_se      = VW'(w_s_clamp);
        if (w_slider) begin
            w_raw  = r_sgn ? (w_se + jac_pkg::HALF_Q16) : (w_se <<< 1);
            w_conv = w_inv ? (jac_pkg::ONE_Q16 - w_raw) : w_raw;
        end else begin
            w_raw  = r_sgn ? (w_se <<< 1) : ((w_se <<< 2) - jac_pkg::ONE_Q16);
            w_conv = w_inv ? -w_raw : w_raw;
        end
    end

    // deadzone
    logic signed [VW-1:0] w_vneg;
    logic [16:0]          w_av, w_diff;
    logic [15:0]          w_dzv, w_den;
    logic                 w_dz_on, w_below;

    assign w_vneg  = -r_v;
    assign w_av    = r_v[VW-1] ? w_vneg[16:0] : r_v[16:0];
    assign w_dzv   = {w_d, 8'h00};
    assign w_den   = {CW'(9'd256 - {1'b0, w_d}), 8'h00};
    assign w_dz_on = w_cond && !w_slider && (w_d != '0);
    assign w_below = w_av < {1'b0, w_dzv};
    assign w_diff  = w_av - {1'b0, w_dzv};

    // restoring divider step
    logic [16:0] w_trial, w_sub;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[16]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    logic [16:0]          w_qsat;
    logic signed [VW-1:0] w_qs;

    assign w_qsat = (r_quo > 17'd65536) ? 17'd65536 : r_quo;
    assign w_qs   = {1'b0, w_qsat};

    // EMA multiplier, shared by both products
    logic signed [VW-1:0] w_ema_cur, w_mx, w_ema_new;
    logic [CW-1:0]        w_mc;
    logic signed [AW-1:0] w_prod;

    assign w_ema_cur = r_ema[w_idx];
    assign w_mx      = i_cmd.mul1 ? w_ema_cur : r_v;
    assign w_mc      = i_cmd.mul1 ? CW'(9'd256 - {1'b0, w_a}) : w_a;
    assign w_prod    = AW'(w_mx) * AW'($signed({1'b0, w_mc}));
    assign w_ema_new = r_acc[VW+7:8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis    <= i_axis_index;
            r_sample  <= i_sample;
            r_sgn     <= i_source_signed;
            r_present <= i_source_present;
        end
        if (i_cmd.conv) begin
            r_v <= w_conv;
        end
        if (i_cmd.dz_init) begin
            r_neg <= r_v[VW-1];
            r_den <= w_den;
            r_rem <= {1'b0, w_diff[15:1]};
            r_quo <= {w_diff[0], 1'b0, w_den[15:1]};
            if (w_dz_on && w_below) begin
                r_v <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[15:0] : w_trial[15:0];
            r_quo <= {r_quo[15:0], w_ge};
        end
        if (i_cmd.dz_fin) begin
            r_v <= r_neg ? -w_qs : w_qs;
        end
        if (i_cmd.mul1) begin
            r_acc <= w_prod;
        end
        if (i_cmd.mul2) begin
            r_acc <= r_acc + w_prod + AW'(128);
        end
        if (i_cmd.ema_fin) begin
            r_v          <= w_ema_new;
            r_ema[w_idx] <= w_ema_new;
        end
        if (i_cmd.ema_bypass && w_cond) begin
            r_ema[w_idx] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_valid <= '0;
        end else if (i_cmd.load && i_restart) begin
            r_ema_valid <= '0;
        end else if (i_cmd.ema_fin || (i_cmd.ema_bypass && w_cond)) begin
            r_ema_valid[w_idx] <= 1'b1;
        end
    end

    // output scaling
    logic signed [VW-1:0] w_lo, w_cl, w_clneg;
    logic [16:0]          w_mag;
    logic [32:0]          w_mag33, w_scl;
    logic [15:0]          w_mag_o;
    logic signed [15:0]   w_result;

    always_comb begin
        w_lo     = w_slider ? '0 : -jac_pkg::ONE_Q16;
        w_cl     = (r_v > jac_pkg::ONE_Q16) ? jac_pkg::ONE_Q16 : ((r_v < w_lo) ? w_lo : r_v);
        w_clneg  = -w_cl;
        w_mag    = w_cl[VW-1] ? w_clneg[16:0] : w_cl[16:0];
        w_mag33  = 33'(w_mag);
        w_scl    = (w_mag33 << 15) - w_mag33 + 33'd32768;
        w_mag_o  = {1'b0, w_scl[30:16]};
        w_result = '0;
        if (w_cond) begin
            w_result = w_cl[VW-1] ? -$signed(w_mag_o) : $signed(w_mag_o);
        end else if (w_hat && r_sample >= 0 && r_sample <= 16'sd7) begin
            w_result = $signed(16'(r_sample[2:0]) + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_axis  <= r_axis;
            r_out_value <= w_result;
        end
    end

    assign o_stat.div_needed = w_dz_on && !w_below;
    assign o_stat.smooth     = w_cond && (w_a != '0) && r_ema_valid[w_idx];
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_axis_out     = r_out_axis;
    assign o_output_value = r_out_value;

endmodule

FILE: hdl/joystick_axis_conditioner.sv
// Top level of the joystick axis conditioner: stream ports and config port.
// Depends on jac_pkg, jac_ctrl and jac_datapath.
//
// Usage:
//  - Slave stream (i_s_*): one request per axis sample. The axis index, the
//    signed-source flag and the present flag travel in tuser; the sample and
//    the restart flag travel in tdata.
//  - Master stream (o_m_*): one result per request, the axis echo in tuser
//    and the conditioned value in tdata.
//  - Config port (i_cfg_*): index 0 invert mask, 1 deadzone table,
//    2 smoothing table. Always ready; write only while no request is in flight.
//  - Sequence: after acceptance a request passes conversion, the deadzone check,
//    the EMA step and the output state. The 17-step restoring divider for the
//    deadzone rescale runs only when a deadzone division is needed and dominates;
//    smoothing adds the EMA2 and EMA3 states, both products on the shared multiplier.
//  - Flow: one request is in work at a time, and the next is taken once the
//    result has moved to the output register, even if the receiver has not
//    taken it yet.
//  - Stall: a held result stays on the master port; work finishing behind it
//    waits in the controller until the output register frees.
//  - Reset clears the config registers, all EMA valid flags, the controller
//    and the output valid.
module joystick_axis_conditioner #(
    parameter int NUM_AXES = jac_pkg::NUM_AXES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [23:0]                       i_s_tdata,  // [15:0] sample, [16] restart
    input  logic [5:0]                        i_s_tuser,  // [3:0] axis_index,
                                                          // [4] source_signed,
                                                          // [5] source_present
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata,  // [15:0] output_value
    output logic [3:0]                        o_m_tuser,  // [3:0] axis_out
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jac_pkg::TABLE_W-1:0]       i_cfg_data
);

    jac_pkg::t_dp_cmd  w_cmd;
    jac_pkg::t_dp_stat w_stat;
    logic signed [jac_pkg::SAMPLE_W-1:0] w_out_value;

    // config writes are always accepted and registered in the next cycle
    assign o_cfg_ready = 1'b1;

    jac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    jac_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_axis_index     (i_s_tuser[3:0]),
        .i_sample         ($signed(i_s_tdata[15:0])),
        .i_source_signed  (i_s_tuser[4]),
        .i_source_present (i_s_tuser[5]),
        .i_restart        (i_s_tdata[16]),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_axis_out       (o_m_tuser),
        .o_output_value   (w_out_value)
    );

    assign o_m_tdata = w_out_value;

`ifndef SYNTHESIS
    // never load a result over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output register overwritten");

    // one request at a time
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // clamp keeps results inside +-32767
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata != 16'h8000))
        else $error("result outside the clamp range");
`endif

endmodule
